[rtl/cbf_pkg.sv]
`default_nettype none

package cbf_pkg;

    // Framebuffer geometry
    localparam int PLANES  = 3;
    localparam int DEPTH   = PLANES * 8;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;

    // Command codes
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd0;
    localparam logic [2:0] CMD_SET_PIX   = 3'd1;
    localparam logic [2:0] CMD_CLR_PIX   = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_READ_NB   = 3'd4;
    localparam logic [2:0] CMD_PLACE     = 3'd5;
    localparam logic [2:0] CMD_WALK      = 3'd6;

    // Headings
    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    // Draw modes
    localparam logic [1:0] MODE_MOVE  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_FULL  = 2'd2;

    localparam logic [7:0] PIX_OFF_GRID = 8'hff;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] level;
        logic [1:0] heading;
        logic [1:0] draw_mode;
        logic [7:0] step_count;
    } cbf_cmd_t;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [7:0] cursor_x;
        logic [7:0] cursor_y;
    } cbf_rsp_t;

    // Request from the sequencer to the plane store
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr_all;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } cbf_req_t;

endpackage

`default_nettype wire

[rtl/cbf_ram.sv]
`default_nettype none

module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/cbf_store.sv]
`default_nettype none

module cbf_store (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cbf_pkg::cbf_req_t req,
    output logic [7:0]         rdata
);
    import cbf_pkg::*;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [7:0]       ram_q;

    cbf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.addr),
        .wdata (req.wdata),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (ram_q)
    );

    // Row valid bits: a row never written since reset or clear reads as zero
    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (req.clr_all)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.addr] = 1'b1;
        end
        if (req.rd_en)
        begin
            rd_valid_next = valid_reg[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rdata = rd_valid_reg ? ram_q : 8'h00;

endmodule

`default_nettype wire

[rtl/cursor_bitplane_framebuffer.sv]
`default_nettype none
// 8x8 bitplane framebuffer with a drawing cursor.
// Command channel (cmd_valid / cmd_stall / cmd_item) takes one command item;
// result channel (rsp_valid / rsp_stall / rsp_item) returns exactly one item
// per command with the read value and the cursor position afterwards.
// Commands are processed one at a time; cmd_stall is high while one is busy.
// Work from accept to the result, with P = PLANES: clear all, an unused code
// and a place that does not draw go straight to the result; set / clear pixel
// and a drawing place update each of the P planes; read and read neighbour
// fetch one row, or none when the pixel is off the grid; a walk of n steps
// moves the cursor n times and, if drawing, updates the P planes at each step.
// Each plane update is a read then a write of one row in the plane RAM.
// Clear all resets the per-row valid bits.
// Reset clears the image, the cursor and all handshake state at once.
// A finished result waits in the output register while rsp_stall is high;
// a new command is still accepted, and its result waits until that slot frees.

module cursor_bitplane_framebuffer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire cbf_pkg::cbf_cmd_t cmd_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output cbf_pkg::cbf_rsp_t      rsp_item
);
    import cbf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD     = 7'b0000010,
        S_WR     = 7'b0000100,
        S_RDPIX  = 7'b0001000,
        S_RDWAIT = 7'b0010000,
        S_WALK   = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           cur_x_reg, cur_x_next;
    logic [7:0]           cur_y_reg, cur_y_next;
    logic [7:0]           x_reg, x_next;
    logic [7:0]           y_reg, y_next;
    logic [7:0]           lvl_reg, lvl_next;
    logic [1:0]           head_reg, head_next;
    logic [1:0]           mode_reg, mode_next;
    logic [7:0]           steps_reg, steps_next;
    logic [PLANE_W-1:0]   plane_reg, plane_next;
    logic                 walking_reg, walking_next;
    logic [7:0]           val_reg, val_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    cbf_rsp_t             rsp_reg, rsp_next;

    cbf_req_t             req;
    logic [7:0]           rdata;
    logic [15:0]          nb_xy;
    logic [15:0]          walk_xy;
    logic [7:0]           bit_mask;
    logic                 load_rsp;

    // Single step of the cursor in a heading; bytes wrap
    function automatic logic [15:0] step_xy(input logic [7:0] x, input logic [7:0] y,
                                            input logic [1:0] h);
        logic [7:0] nx;
        logic [7:0] ny;
        nx = x;
        ny = y;
        case (h)
            HEAD_RIGHT: nx = x + 8'd1;
            HEAD_DOWN:  ny = y + 8'd1;
            HEAD_LEFT:  nx = x - 8'd1;
            default:    ny = y - 8'd1;
        endcase
        return {nx, ny};
    endfunction

    cbf_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (rdata)
    );

    assign nb_xy    = step_xy(cmd_item.pos_x, cmd_item.pos_y, cmd_item.heading);
    assign walk_xy  = step_xy(cur_x_reg, cur_y_reg, head_reg);
    assign bit_mask = 8'h01 << x_reg[2:0];
    assign load_rsp = (state_reg == S_FIN) && !(rsp_valid_reg && rsp_stall);

    // Command sequencer
    always_comb
    begin
        state_next   = state_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        lvl_next     = lvl_reg;
        head_next    = head_reg;
        mode_next    = mode_reg;
        steps_next   = steps_reg;
        plane_next   = plane_reg;
        walking_next = walking_reg;
        val_next     = val_reg;
        req          = '0;
        req.addr     = ADDR_W'({plane_reg, y_reg[2:0]});

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    x_next       = cmd_item.pos_x;
                    y_next       = cmd_item.pos_y;
                    head_next    = cmd_item.heading;
                    mode_next    = cmd_item.draw_mode;
                    steps_next   = cmd_item.step_count;
                    plane_next   = '0;
                    walking_next = 1'b0;
                    val_next     = 8'h00;
                    state_next   = S_FIN;
                    case (cmd_item.cmd)
                        CMD_CLEAR_ALL:
                        begin
                            req.clr_all = 1'b1;
                        end
                        CMD_SET_PIX:
                        begin
                            lvl_next   = cmd_item.level;
                            state_next = S_RD;
                        end
                        CMD_CLR_PIX:
                        begin
                            lvl_next   = 8'd0;
                            state_next = S_RD;
                        end
                        CMD_READ:
                        begin
                            state_next = S_RDPIX;
                        end
                        CMD_READ_NB:
                        begin
                            x_next     = nb_xy[15:8];
                            y_next     = nb_xy[7:0];
                            state_next = S_RDPIX;
                        end
                        CMD_PLACE:
                        begin
                            cur_x_next = cmd_item.pos_x;
                            cur_y_next = cmd_item.pos_y;
                            if (cmd_item.draw_mode == MODE_CLEAR)
                            begin
                                lvl_next   = 8'd0;
                                state_next = S_RD;
                            end
                            else if (cmd_item.draw_mode == MODE_FULL)
                            begin
                                lvl_next   = 8'(PLANES);
                                state_next = S_RD;
                            end
                        end
                        CMD_WALK:
                        begin
                            walking_next = 1'b1;
                            state_next   = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (steps_reg == 8'd0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    steps_next = steps_reg - 8'd1;
                    cur_x_next = walk_xy[15:8];
                    cur_y_next = walk_xy[7:0];
                    x_next     = walk_xy[15:8];
                    y_next     = walk_xy[7:0];
                    plane_next = '0;
                    if (mode_reg == MODE_CLEAR)
                    begin
                        lvl_next   = 8'd0;
                        state_next = S_RD;
                    end
                    else if (mode_reg == MODE_FULL)
                    begin
                        lvl_next   = 8'(PLANES);
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                req.rd_en  = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                // Thermometer code: plane lit when its index is below the level
                req.wr_en = 1'b1;
                if (8'(plane_reg) < lvl_reg)
                begin
                    req.wdata = rdata | bit_mask;
                end
                else
                begin
                    req.wdata = rdata & ~bit_mask;
                end
                if (plane_reg == PLANE_W'(PLANES - 1))
                begin
                    state_next = walking_reg ? S_WALK : S_FIN;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_RDPIX:
            begin
                if ((x_reg > 8'd7) || (y_reg > 8'd7))
                begin
                    val_next   = PIX_OFF_GRID;
                    state_next = S_FIN;
                end
                else
                begin
                    req.rd_en  = 1'b1;
                    req.addr   = ADDR_W'(y_reg[2:0]);
                    state_next = S_RDWAIT;
                end
            end
            S_RDWAIT:
            begin
                val_next   = {7'd0, rdata[x_reg[2:0]]};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (load_rsp)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.pixel_value = val_reg;
            rsp_next.cursor_x    = cur_x_reg;
            rsp_next.cursor_y    = cur_y_reg;
        end
    end

    // Control and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_x_reg     <= 8'd0;
            cur_y_reg     <= 8'd0;
            plane_reg     <= '0;
            walking_reg   <= 1'b0;
            steps_reg     <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            plane_reg     <= plane_next;
            walking_reg   <= walking_next;
            steps_reg     <= steps_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        lvl_reg  <= lvl_next;
        head_reg <= head_next;
        mode_reg <= mode_next;
        val_reg  <= val_next;
        rsp_reg  <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    // Checks
    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RD) || (state_reg == S_WR)) |-> (32'(plane_reg) < PLANES))
        else $error("plane index out of range");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> $past(state_reg == S_RD))
        else $error("row write without preceding read");

    a_wait_after_rdpix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDWAIT) |-> $past(state_reg == S_RDPIX))
        else $error("pixel read wait without read");

    a_rsp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_rsp |=> (rsp_valid_reg && (state_reg == S_IDLE)))
        else $error("result not loaded into output slot");

    a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && (cmd_item.cmd == CMD_CLEAR_ALL)) |=> (state_reg == S_FIN))
        else $error("clear all did not finish in one cycle");

endmodule

`default_nettype wire

[verif/tb_cursor_bitplane_framebuffer.sv]
`timescale 1ns / 1ps

module tb_cursor_bitplane_framebuffer;
    import cbf_pkg::*;

    // No code in the package for the spare command and draw mode
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 400;
    localparam int PAUSE_AT     = 260;  // sender waits for all results here
    localparam int HOLD_AFTER   = 120;  // commands accepted before the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 64;
    // Covers the longest walk, the long hold and stalls, then margin
    localparam int IDLE_LIMIT   = 20000;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    cbf_cmd_t cmd_item  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    cbf_rsp_t rsp_item;

    // Typed-in result that travels with the item on the command side
    logic     pin_valid = 1'b0;
    cbf_rsp_t pin_rsp   = '0;

    cursor_bitplane_framebuffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Framebuffer and cursor predictor
    // ------------------------------------------------------------------
    logic [7:0] img_rows [DEPTH];
    logic [7:0] cur_col = '0;
    logic [7:0] cur_row = '0;

    initial
    begin
        foreach (img_rows[i])
            img_rows[i] = '0;
    end

    // Thermometer write: plane p lit when p < lvl, coordinates modulo 8
    function automatic void paint(input logic [7:0] x, y, input int unsigned lvl);
        for (int p = 0; p < PLANES; p++)
        begin
            img_rows[p * 8 + y[2:0]][x[2:0]] = (p < lvl);
        end
    endfunction

    function automatic logic [7:0] plane0_at(input logic [7:0] x, y);
        if (x > 8'd7 || y > 8'd7)
            return PIX_OFF_GRID;
        return {7'd0, img_rows[y[2:0]][x[2:0]]};
    endfunction

    // One step in a heading; raw bytes wrap modulo 256
    function automatic void nudge(inout logic [7:0] x, inout logic [7:0] y,
                                  input logic [1:0] h);
        case (h)
            HEAD_RIGHT: x = x + 8'd1;
            HEAD_DOWN:  y = y + 8'd1;
            HEAD_LEFT:  x = x - 8'd1;
            default:    y = y - 8'd1;
        endcase
    endfunction

    function automatic void park(input logic [7:0] x, y, input logic [1:0] mode);
        cur_col = x;
        cur_row = y;
        if (mode == MODE_CLEAR)
            paint(x, y, 0);
        else if (mode == MODE_FULL)
            paint(x, y, PLANES);
    endfunction

    function automatic cbf_rsp_t apply_cmd(input cbf_cmd_t c);
        cbf_rsp_t   r;
        logic [7:0] x;
        logic [7:0] y;
        r = '0;
        x = c.pos_x;
        y = c.pos_y;
        case (c.cmd)
            CMD_CLEAR_ALL:
                foreach (img_rows[i])
                    img_rows[i] = '0;
            CMD_SET_PIX: paint(x, y, c.level);
            CMD_CLR_PIX: paint(x, y, 0);
            CMD_READ:    r.pixel_value = plane0_at(x, y);
            CMD_READ_NB:
            begin
                nudge(x, y, c.heading);
                r.pixel_value = plane0_at(x, y);
            end
            CMD_PLACE:   park(x, y, c.draw_mode);
            CMD_WALK:
                for (int i = 0; i < c.step_count; i++)
                begin
                    x = cur_col;
                    y = cur_row;
                    nudge(x, y, c.heading);
                    park(x, y, c.draw_mode);
                end
            default: ;
        endcase
        r.cursor_x = cur_col;
        r.cursor_y = cur_row;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check results, then predict for the accepted command
    // ------------------------------------------------------------------
    cbf_rsp_t    rsp_q [$];
    int unsigned n_cmd_acc    = 0;  // nonblocking, read by the receiver
    int unsigned idle_cycles  = 0;  // nonblocking, read by the watchdog
    int unsigned n_errors     = 0;
    int unsigned n_rsp_seen   = 0;
    int unsigned n_walk_steps = 0;
    int unsigned n_off_grid   = 0;

    always @(posedge clk)
    begin : monitor
        cbf_rsp_t got;
        cbf_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = rsp_item;
                n_rsp_seen++;
                if (rsp_q.size() == 0)
                begin
                    $error("result item with nothing pending: %h", got);
                    n_errors++;
                end
                else
                begin
                    want = rsp_q.pop_front();
                    if (got.pixel_value !== want.pixel_value)
                    begin
                        $error("pixel_value: expected %0d, got %0d",
                               want.pixel_value, got.pixel_value);
                        n_errors++;
                    end
                    if (got.cursor_x !== want.cursor_x)
                    begin
                        $error("cursor_x: expected %0d, got %0d",
                               want.cursor_x, got.cursor_x);
                        n_errors++;
                    end
                    if (got.cursor_y !== want.cursor_y)
                    begin
                        $error("cursor_y: expected %0d, got %0d",
                               want.cursor_y, got.cursor_y);
                        n_errors++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                want = apply_cmd(cmd_item);
                if ((cmd_item.cmd == CMD_READ || cmd_item.cmd == CMD_READ_NB)
                    && want.pixel_value == PIX_OFF_GRID)
                    n_off_grid++;
                if (cmd_item.cmd == CMD_WALK)
                    n_walk_steps += cmd_item.step_count;
                if (pin_valid)
                    want = pin_rsp;
                rsp_q.push_back(want);
                n_cmd_acc <= n_cmd_acc + 1;
            end
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Timeout on a stuck handshake
    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $error("no item moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: segments of free flow and random stalls, one long hold
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned seg;
        int unsigned kind;
        bit          held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            seg  = $urandom_range(10, 60);
            kind = $urandom_range(0, 2);
            repeat (seg)
            begin
                @(posedge clk);
                case (kind)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= 1'($urandom_range(0, 1));
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
            // Hold off long enough that the block backs up into cmd_stall
            if (!held && n_cmd_acc >= HOLD_AFTER)
            begin
                held = 1'b1;
                @(posedge clk);
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic feed(input cbf_cmd_t it, input bit pinned, input cbf_rsp_t want);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        pin_valid <= pinned;
        pin_rsp   <= want;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every pending result has arrived
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (rsp_q.size() != 0);
        @(posedge clk);
    endtask

    function automatic cbf_cmd_t random_cmd();
        cbf_cmd_t    c;
        int unsigned pick;
        pick  = $urandom_range(0, 99);
        c.cmd = (pick < 3)  ? CMD_CLEAR_ALL :
                (pick < 21) ? CMD_SET_PIX :
                (pick < 29) ? CMD_CLR_PIX :
                (pick < 47) ? CMD_READ :
                (pick < 60) ? CMD_READ_NB :
                (pick < 72) ? CMD_PLACE :
                (pick < 96) ? CMD_WALK : CMD_UNUSED;
        // Mostly on the grid; the full byte range now and then
        c.pos_x      = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
        c.pos_y      = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
        c.level      = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 4))
                                                   : 8'($urandom_range(0, 255));
        c.heading    = 2'($urandom_range(0, 3));
        c.draw_mode  = 2'($urandom_range(0, 3));
        // Long walks are slow, so keep most of them short
        c.step_count = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 10))
                                                   : 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Directed table; rows with pinned set carry a typed-in pixel value
    typedef struct {
        cbf_cmd_t   item;
        bit         pinned;
        logic [7:0] pix;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic void add_row(input logic [2:0] cmd, input logic [7:0] x, y, lvl,
                                    input logic [1:0] h, m, input logic [7:0] steps,
                                    input bit pinned = 1'b0, input logic [7:0] pix = '0);
        dir_row_t r;
        r.item   = '{cmd, x, y, lvl, h, m, steps};
        r.pinned = pinned;
        r.pix    = pix;
        dir_rows.push_back(r);
    endfunction

    initial
    begin : stimulus
        cbf_rsp_t want;
        // Reads after reset, off the grid, and across the low edges
        add_row(CMD_READ,    8'd0,   8'd0,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, 8'd0);
        add_row(CMD_READ,    8'd8,   8'd0,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, PIX_OFF_GRID);
        add_row(CMD_READ,    8'd0,   8'd255, 8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, PIX_OFF_GRID);
        add_row(CMD_READ_NB, 8'd0,   8'd0,   8'd0, HEAD_LEFT,  MODE_MOVE, 8'd0, 1, PIX_OFF_GRID);
        add_row(CMD_READ_NB, 8'd0,   8'd0,   8'd0, HEAD_UP,    MODE_MOVE, 8'd0, 1, PIX_OFF_GRID);
        // Highest level lights every plane; off-grid writes wrap modulo 8
        add_row(CMD_SET_PIX, 8'd7,   8'd7,   8'd255, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, 8'd0);
        add_row(CMD_READ,    8'd7,   8'd7,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, 8'd1);
        add_row(CMD_SET_PIX, 8'd15,  8'd15,  8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_READ,    8'd7,   8'd7,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, 8'd0);
        add_row(CMD_SET_PIX, 8'd255, 8'd0,   8'd1, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_READ_NB, 8'd6,   8'd0,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_CLR_PIX, 8'd7,   8'd0,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_READ_NB, 8'd7,   8'd1,   8'd0, HEAD_UP,    MODE_MOVE, 8'd0);
        add_row(CMD_SET_PIX, 8'd3,   8'd3,   8'd2, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_READ_NB, 8'd3,   8'd2,   8'd0, HEAD_DOWN,  MODE_MOVE, 8'd0);
        add_row(CMD_CLEAR_ALL, 8'd0, 8'd0,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_READ,    8'd3,   8'd3,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0, 1, 8'd0);
        // Cursor: far corner, wrap past 255, empty walk, spare mode, long walk
        add_row(CMD_PLACE,   8'd255, 8'd255, 8'd0, HEAD_RIGHT, MODE_FULL, 8'd0);
        add_row(CMD_READ,    8'd7,   8'd7,   8'd0, HEAD_RIGHT, MODE_MOVE, 8'd0);
        add_row(CMD_WALK,    8'd0,   8'd0,   8'd0, HEAD_RIGHT, MODE_CLEAR, 8'd1);
        add_row(CMD_WALK,    8'd0,   8'd0,   8'd0, HEAD_DOWN,  MODE_FULL, 8'd0);
        add_row(CMD_PLACE,   8'd0,   8'd0,   8'd0, HEAD_RIGHT, MODE_SPARE, 8'd0);
        add_row(CMD_WALK,    8'd0,   8'd0,   8'd0, HEAD_UP,    MODE_FULL, 8'd255);
        add_row(CMD_WALK,    8'd0,   8'd0,   8'd0, HEAD_LEFT,  MODE_CLEAR, 8'd5);
        add_row(CMD_UNUSED,  8'd255, 8'd255, 8'd255, HEAD_UP,  MODE_SPARE, 8'd255);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            want = '{dir_rows[i].pix, 8'd0, 8'd0};
            feed(dir_rows[i].item, dir_rows[i].pinned, want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PAUSE_AT)
                drain_results();
            feed(random_cmd(), 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Covered %0d command items, %0d cursor steps walked, %0d reads off the grid",
                 n_cmd_acc, n_walk_steps, n_off_grid);
        $display("Checked %0d result items, %0d still pending", n_rsp_seen, rsp_q.size());
        if (n_errors == 0 && rsp_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/cbf_pkg.sv
rtl/cbf_ram.sv
rtl/cbf_store.sv
rtl/cursor_bitplane_framebuffer.sv
verif/tb_cursor_bitplane_framebuffer.sv
